[rtl/tmws_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmws_pkg
// Shared types, constants and the microcode program of the straight-move
// drive unit.
// ----------------------------------------------------------------------------
package tmws_pkg;

	// Field widths fixed by the register map and the drive format.
	localparam int unsigned TGT_BITS      = 23;
	localparam int unsigned RAMP_BITS     = 23;
	localparam int unsigned GAIN_BITS     = 16;
	localparam int unsigned DRIVE_BITS    = 16;
	localparam int unsigned CFG_DATA_BITS = 23;
	localparam int unsigned CFG_IDX_BITS  = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RAMP     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PROP     = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INTEGRAL = 2'd3;

	// Register values after reset.
	localparam logic [TGT_BITS-1:0]  TGT_RESET      = 23'd16375;
	localparam logic [RAMP_BITS-1:0] RAMP_RESET     = 23'd4010;
	localparam logic [GAIN_BITS-1:0] PROP_RESET     = 16'd1049;
	localparam logic [GAIN_BITS-1:0] INTEGRAL_RESET = 16'd2097;

	// Profile arithmetic: 0.8 in Q15 is 2^17 / 5, offset 0.1 in Q15,
	// and the PI sum goes from Q20 to Q15 with an extra halving.
	localparam int unsigned SCALE_SHIFT  = 17;
	localparam int unsigned DEN_SHIFT    = 2;
	localparam int          Q15_PLATEAU  = 26214;
	localparam int          Q15_OFFSET   = 3277;
	localparam int unsigned PI_SHIFT     = 6;
	localparam int          DRIVE_MAX    = 32767;
	localparam int          DRIVE_MIN    = -32768;

	// Configuration register file.
	typedef struct packed {
		logic [TGT_BITS-1:0]  target;
		logic [RAMP_BITS-1:0] ramp;
		logic [GAIN_BITS-1:0] prop;
		logic [GAIN_BITS-1:0] integral;
	} cfg_t;

	// Datapath status used for conditional jumps.
	typedef struct packed {
		logic past;
		logic tri_shape;
		logic up;
		logic down;
		logic not_uptri;
		logic div_more;
	} flags_t;

	// Datapath operations.
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_END      = 4'd2;
	localparam op_t OP_PLAT     = 4'd3;
	localparam op_t OP_NUM_D    = 4'd4;
	localparam op_t OP_NUM_R    = 4'd5;
	localparam op_t OP_DIV_INIT = 4'd6;
	localparam op_t OP_DIV_STEP = 4'd7;
	localparam op_t OP_DIV_FIN  = 4'd8;
	localparam op_t OP_MUL_P    = 4'd9;
	localparam op_t OP_MUL_I    = 4'd10;
	localparam op_t OP_SUM      = 4'd11;
	localparam op_t OP_EMIT     = 4'd12;

	// Hold conditions: the step waits and its operation is suppressed.
	typedef logic [1:0] hold_t;
	localparam hold_t H_NONE     = 2'd0;
	localparam hold_t H_NO_IN    = 2'd1;
	localparam hold_t H_OUT_FULL = 2'd2;

	// Jump conditions.
	typedef logic [2:0] cond_t;
	localparam cond_t C_NEVER     = 3'd0;
	localparam cond_t C_ALWAYS    = 3'd1;
	localparam cond_t C_NOT_PAST  = 3'd2;
	localparam cond_t C_TRI       = 3'd3;
	localparam cond_t C_UP        = 3'd4;
	localparam cond_t C_DOWN      = 3'd5;
	localparam cond_t C_NOT_UPTRI = 3'd6;
	localparam cond_t C_DIV_MORE  = 3'd7;

	// Program addresses.
	localparam int unsigned STEP_BITS = 5;
	typedef logic [STEP_BITS-1:0] step_t;
	localparam step_t S_IDLE     = 5'd0;
	localparam step_t S_CHECK    = 5'd1;
	localparam step_t S_END      = 5'd2;
	localparam step_t S_SHAPE    = 5'd3;
	localparam step_t S_UP       = 5'd4;
	localparam step_t S_DOWN     = 5'd5;
	localparam step_t S_PLAT     = 5'd6;
	localparam step_t S_TRI      = 5'd7;
	localparam step_t S_NUM_D    = 5'd8;
	localparam step_t S_NUM_R    = 5'd9;
	localparam step_t S_DIV_INIT = 5'd10;
	localparam step_t S_DIV_STEP = 5'd11;
	localparam step_t S_DIV_FIN  = 5'd12;
	localparam step_t S_MUL_P    = 5'd13;
	localparam step_t S_MUL_I    = 5'd14;
	localparam step_t S_SUM      = 5'd15;
	localparam step_t S_EMIT     = 5'd16;
	localparam step_t S_LAST     = 5'd16;

	// One control word of the program.
	typedef struct packed {
		op_t   op;
		hold_t hold;
		cond_t cond;
		step_t target;
	} ucode_t;

	function automatic ucode_t uword(input op_t o, input hold_t h, input cond_t c,
			input step_t t);
		ucode_t w;
		w.op     = o;
		w.hold   = h;
		w.cond   = c;
		w.target = t;
		return w;
	endfunction

	// Microcode program. Unused addresses return to idle.
	function automatic ucode_t ucode_rom(input step_t a);
		ucode_t w;
		unique case (a)
			S_IDLE:     w = uword(OP_LOAD,     H_NO_IN,    C_NEVER,     S_IDLE);
			S_CHECK:    w = uword(OP_NOP,      H_NONE,     C_NOT_PAST,  S_SHAPE);
			S_END:      w = uword(OP_END,      H_OUT_FULL, C_ALWAYS,    S_IDLE);
			S_SHAPE:    w = uword(OP_NOP,      H_NONE,     C_TRI,       S_TRI);
			S_UP:       w = uword(OP_NOP,      H_NONE,     C_UP,        S_NUM_D);
			S_DOWN:     w = uword(OP_NOP,      H_NONE,     C_DOWN,      S_NUM_R);
			S_PLAT:     w = uword(OP_PLAT,     H_NONE,     C_ALWAYS,    S_MUL_P);
			S_TRI:      w = uword(OP_NOP,      H_NONE,     C_NOT_UPTRI, S_NUM_R);
			S_NUM_D:    w = uword(OP_NUM_D,    H_NONE,     C_ALWAYS,    S_DIV_INIT);
			S_NUM_R:    w = uword(OP_NUM_R,    H_NONE,     C_NEVER,     S_IDLE);
			S_DIV_INIT: w = uword(OP_DIV_INIT, H_NONE,     C_NEVER,     S_IDLE);
			S_DIV_STEP: w = uword(OP_DIV_STEP, H_NONE,     C_DIV_MORE,  S_DIV_STEP);
			S_DIV_FIN:  w = uword(OP_DIV_FIN,  H_NONE,     C_NEVER,     S_IDLE);
			S_MUL_P:    w = uword(OP_MUL_P,    H_NONE,     C_NEVER,     S_IDLE);
			S_MUL_I:    w = uword(OP_MUL_I,    H_NONE,     C_NEVER,     S_IDLE);
			S_SUM:      w = uword(OP_SUM,      H_NONE,     C_NEVER,     S_IDLE);
			S_EMIT:     w = uword(OP_EMIT,     H_OUT_FULL, C_ALWAYS,    S_IDLE);
			default:    w = uword(OP_NOP,      H_NONE,     C_ALWAYS,    S_IDLE);
		endcase
		return w;
	endfunction

endpackage

[rtl/tmws_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmws_ifs
// Valid/ready channels of the straight-move drive unit: encoder samples in,
// motor drive words out.
// ----------------------------------------------------------------------------

// Encoder sample channel.
interface tmws_in_if #(
	parameter int COUNT_BITS = 24
);
	logic                         valid;
	logic                         ready;
	logic signed [COUNT_BITS-1:0] left_count;
	logic signed [COUNT_BITS-1:0] right_count;

	modport source (output valid, output left_count, output right_count, input ready);
	modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

// Motor drive channel.
interface tmws_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [tmws_pkg::DRIVE_BITS-1:0]   left_drive;
	logic signed [tmws_pkg::DRIVE_BITS-1:0]   right_drive;
	logic                                     done_res;

	modport source (output valid, output left_drive, output right_drive,
		output done_res, input ready);
	modport sink   (input valid, input left_drive, input right_drive,
		input done_res, output ready);
endinterface

[rtl/tmws_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmws_seq
// Microcode sequencer: step counter, program ROM, hold and jump logic.
// ----------------------------------------------------------------------------
module tmws_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_full,
	input  tmws_pkg::flags_t    flags,
	output tmws_pkg::op_t       op,
	output logic                in_ready
);

	tmws_pkg::step_t  step_q;
	tmws_pkg::ucode_t cw;
	logic             held;
	logic             jump;

	// Fetch the control word of the current step.
	assign cw = tmws_pkg::ucode_rom(step_q);

	// A step holds while its handshake partner is not there.
	always_comb begin
		unique case (cw.hold)
			tmws_pkg::H_NO_IN:    held = !in_valid;
			tmws_pkg::H_OUT_FULL: held = out_full;
			default:              held = 1'b0;
		endcase
	end

	// Jump condition select.
	always_comb begin
		unique case (cw.cond)
			tmws_pkg::C_NEVER:     jump = 1'b0;
			tmws_pkg::C_ALWAYS:    jump = 1'b1;
			tmws_pkg::C_NOT_PAST:  jump = !flags.past;
			tmws_pkg::C_TRI:       jump = flags.tri_shape;
			tmws_pkg::C_UP:        jump = flags.up;
			tmws_pkg::C_DOWN:      jump = flags.down;
			tmws_pkg::C_NOT_UPTRI: jump = flags.not_uptri;
			tmws_pkg::C_DIV_MORE:  jump = flags.div_more;
			default:               jump = 1'b0;
		endcase
	end

	assign op       = held ? tmws_pkg::OP_NOP : cw.op;
	assign in_ready = (cw.hold == tmws_pkg::H_NO_IN);

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tmws_pkg::S_IDLE;
		end else if (!held) begin
			step_q <= jump ? cw.target : tmws_pkg::step_t'(step_q + 1'b1);
		end
	end

	// The program counter stays inside the program.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= tmws_pkg::S_LAST)
		else $error("step counter left the program");

	// The idle step issues no load without a word at the input.
	a_no_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && !in_valid) |-> (op == tmws_pkg::OP_NOP))
		else $error("load issued without an input word");

endmodule

[rtl/tmws_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmws_dp
// Datapath: move state, profile compares, restoring divider, shared PI
// multiplier, drive saturation and the output register.
// ----------------------------------------------------------------------------
module tmws_dp #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tmws_pkg::cfg_t                         cfg,
	input  tmws_pkg::op_t                          op,
	input  logic signed [COUNT_BITS-1:0]           l_in,
	input  logic signed [COUNT_BITS-1:0]           r_in,
	input  logic                                   out_ready,
	output tmws_pkg::flags_t                       flags,
	output logic                                   out_full,
	output logic                                   out_valid,
	output logic signed [tmws_pkg::DRIVE_BITS-1:0] left_drive,
	output logic signed [tmws_pkg::DRIVE_BITS-1:0] right_drive,
	output logic                                   done_res
);

	// Width plan.
	localparam int MAG_BITS  = (COUNT_BITS > 24) ? COUNT_BITS : 24;
	localparam int NW        = MAG_BITS + 1;
	localparam int DW        = MAG_BITS + 2;
	localparam int QB        = MAG_BITS + tmws_pkg::SCALE_SHIFT;
	localparam int DEN_BITS  = tmws_pkg::RAMP_BITS + 3;
	localparam int BW        = QB + 1;
	localparam int CNT_BITS  = $clog2(QB + 1);
	localparam int DIFF_BITS = COUNT_BITS + 2;
	localparam int PW        = tmws_pkg::GAIN_BITS + 1 + DIFF_BITS;
	localparam int SW        = PW + 1;
	localparam int PIW       = SW - tmws_pkg::PI_SHIFT;
	localparam int XW        = ((BW > PIW) ? BW : PIW) + 2;

	localparam logic signed [XW-1:0] X_OFFSET = XW'(tmws_pkg::Q15_OFFSET);
	localparam logic signed [XW-1:0] X_MAX    = XW'(tmws_pkg::DRIVE_MAX);
	localparam logic signed [XW-1:0] X_MIN    = XW'(tmws_pkg::DRIVE_MIN);
	localparam logic signed [BW-1:0] B_PLAT   = BW'(tmws_pkg::Q15_PLATEAU);

	// Move state and the latched sample.
	logic signed [COUNT_BITS-1:0] travelled_q;
	logic signed [COUNT_BITS-1:0] last_left_q;
	logic signed [COUNT_BITS-1:0] last_right_q;
	logic signed [COUNT_BITS-1:0] l_q;
	logic signed [COUNT_BITS-1:0] r_q;

	// Divider and accumulator registers.
	logic signed [NW-1:0]         num_q;
	logic [DEN_BITS-1:0]          den_q;
	logic [DEN_BITS-1:0]          rem_q;
	logic [QB-1:0]                quo_q;
	logic                         neg_q;
	logic [CNT_BITS-1:0]          cnt_q;
	logic signed [BW-1:0]         base_q;
	logic signed [PW-1:0]         prod_q;
	logic signed [SW-1:0]         acc_q;

	// Output register.
	logic                                   out_valid_q;
	logic signed [tmws_pkg::DRIVE_BITS-1:0] left_q;
	logic signed [tmws_pkg::DRIVE_BITS-1:0] right_q;
	logic                                   done_q;

	logic [tmws_pkg::RAMP_BITS-1:0] ramp_eff;
	logic signed [DW-1:0]           d_w;
	logic signed [DW-1:0]           tgt_w;
	logic signed [DW-1:0]           ramp_w;
	logic signed [DW-1:0]           togo_w;
	logic [NW-1:0]                  num_abs;
	logic [DEN_BITS:0]              trial;
	logic                           trial_ge;
	logic signed [DIFF_BITS-1:0]    ll;
	logic signed [DIFF_BITS-1:0]    rr;
	logic signed [DIFF_BITS-1:0]    ddiff;
	logic signed [DIFF_BITS-1:0]    lr;
	logic signed [tmws_pkg::GAIN_BITS:0] mul_a;
	logic signed [DIFF_BITS-1:0]    mul_b;
	logic signed [PW-1:0]           mul_p;
	logic signed [XW-1:0]           base_x;
	logic signed [XW-1:0]           pi_x;
	logic signed [XW-1:0]           sum_l;
	logic signed [XW-1:0]           sum_r;

	function automatic logic signed [tmws_pkg::DRIVE_BITS-1:0] sat_drive(
			input logic signed [XW-1:0] v);
		logic signed [XW-1:0] c;
		if (v > X_MAX) begin
			c = X_MAX;
		end else if (v < X_MIN) begin
			c = X_MIN;
		end else begin
			c = v;
		end
		return c[tmws_pkg::DRIVE_BITS-1:0];
	endfunction

	// Profile compares on the travelled count; a zero ramp acts as one.
	assign ramp_eff = (cfg.ramp == '0) ? tmws_pkg::RAMP_BITS'(1) : cfg.ramp;
	assign d_w      = DW'(travelled_q);
	assign tgt_w    = {{(DW-tmws_pkg::TGT_BITS){1'b0}}, cfg.target};
	assign ramp_w   = {{(DW-tmws_pkg::RAMP_BITS){1'b0}}, ramp_eff};
	assign togo_w   = tgt_w - d_w;

	assign flags.past      = d_w > tgt_w;
	assign flags.tri_shape = (ramp_w <<< 1) >= tgt_w;
	assign flags.not_uptri = !((d_w <<< 1) < tgt_w);
	assign flags.up        = d_w < ramp_w;
	assign flags.down      = togo_w <= ramp_w;
	assign flags.div_more  = cnt_q != CNT_BITS'(1);

	// One restoring division step per cycle.
	assign num_abs  = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
	assign trial    = {rem_q, quo_q[QB-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	// Wheel-sync operands and the shared multiplier.
	assign ll    = DIFF_BITS'(l_q);
	assign rr    = DIFF_BITS'(r_q);
	assign ddiff = (ll - DIFF_BITS'(last_left_q)) - (rr - DIFF_BITS'(last_right_q));
	assign lr    = ll - rr;
	assign mul_a = (op == tmws_pkg::OP_MUL_I) ? $signed({1'b0, cfg.integral})
		: $signed({1'b0, cfg.prop});
	assign mul_b = (op == tmws_pkg::OP_MUL_I) ? lr : ddiff;
	assign mul_p = mul_a * mul_b;

	// Drive sums: the PI term is the accumulator floored by the shift.
	assign base_x = XW'(base_q);
	assign pi_x   = XW'($signed(acc_q[SW-1:tmws_pkg::PI_SHIFT]));
	assign sum_l  = base_x + X_OFFSET - pi_x;
	assign sum_r  = base_x + X_OFFSET + pi_x;

	// Move state, cleared at reset and at the end of a move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travelled_q  <= '0;
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (op == tmws_pkg::OP_END) begin
			travelled_q  <= '0;
			last_left_q  <= '0;
			last_right_q <= '0;
		end else if (op == tmws_pkg::OP_EMIT) begin
			travelled_q  <= l_q;
			last_left_q  <= l_q;
			last_right_q <= r_q;
		end
	end

	// Working registers driven by the control word.
	always_ff @(posedge clk) begin
		case (op)
			tmws_pkg::OP_LOAD: begin
				l_q <= l_in;
				r_q <= r_in;
			end
			tmws_pkg::OP_PLAT: begin
				base_q <= B_PLAT;
			end
			tmws_pkg::OP_NUM_D: begin
				num_q <= d_w[NW-1:0];
			end
			tmws_pkg::OP_NUM_R: begin
				num_q <= togo_w[NW-1:0];
			end
			tmws_pkg::OP_DIV_INIT: begin
				den_q <= ({3'b000, ramp_eff} << tmws_pkg::DEN_SHIFT) + {3'b000, ramp_eff};
				quo_q <= {num_abs[MAG_BITS-1:0], {tmws_pkg::SCALE_SHIFT{1'b0}}};
				rem_q <= '0;
				neg_q <= num_q[NW-1];
			end
			tmws_pkg::OP_DIV_STEP: begin
				rem_q <= trial_ge ? DEN_BITS'(trial - {1'b0, den_q}) : trial[DEN_BITS-1:0];
				quo_q <= {quo_q[QB-2:0], trial_ge};
			end
			tmws_pkg::OP_DIV_FIN: begin
				base_q <= neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
			end
			tmws_pkg::OP_MUL_P: begin
				prod_q <= mul_p;
			end
			tmws_pkg::OP_MUL_I: begin
				acc_q  <= SW'(prod_q);
				prod_q <= mul_p;
			end
			tmws_pkg::OP_SUM: begin
				acc_q <= acc_q + SW'(prod_q);
			end
			default: begin
			end
		endcase
	end

	// Divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (op == tmws_pkg::OP_DIV_INIT) begin
			cnt_q <= CNT_BITS'(QB);
		end else if (op == tmws_pkg::OP_DIV_STEP) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Output word register; it is written only when free or being taken.
	assign out_full = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == tmws_pkg::OP_EMIT || op == tmws_pkg::OP_END) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == tmws_pkg::OP_EMIT) begin
			left_q  <= sat_drive(sum_l);
			right_q <= sat_drive(sum_r);
			done_q  <= 1'b0;
		end else if (op == tmws_pkg::OP_END) begin
			left_q  <= '0;
			right_q <= '0;
			done_q  <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign left_drive  = left_q;
	assign right_drive = right_q;
	assign done_res    = done_q;

	// A result is never written over a word that still waits.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(op == tmws_pkg::OP_EMIT || op == tmws_pkg::OP_END) |-> !out_full)
		else $error("output word overwritten while stalled");

	// Ending a move leaves all move state at zero.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(op == tmws_pkg::OP_END) |=>
		(travelled_q == '0 && last_left_q == '0 && last_right_q == '0))
		else $error("move state not cleared at end of move");

	// The partial remainder stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(op == tmws_pkg::OP_DIV_STEP) |=> (rem_q < den_q))
		else $error("divider remainder out of range");

endmodule

[rtl/trapezoid_move_with_wheel_sync_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_move_with_wheel_sync_unit
// Straight-move drive profile with PI wheel synchronization.
//
// in_ch carries one word per control sample: the left and right encoder
// counts since the move started. out_ch returns one word for each: the left
// and right drives in Q1.15 and done_res, which is high on the word that
// ends the move (drives zero, move state cleared for the next move).
// Registers are written on the cfg port (target, ramp, P gain, I gain); the
// user must write them only while the unit is idle, and the block itself
// does not enforce it. A microcode sequencer runs one word at a time. It
// ends the move, takes the plateau value or, on a ramp, runs the restoring
// divider that resolves one quotient bit per cycle; the ramp down outside
// the triangle takes one more compare. A new word is accepted as soon as
// the program is back at its idle step. A finished word waits in the
// output register while the next is computed; if it is still not taken
// when the next result is ready, the program holds on its final step.
// After reset the registers hold their default values, the move state is
// zero and no word is pending.
// ----------------------------------------------------------------------------
module trapezoid_move_with_wheel_sync_unit #(
	parameter int COUNT_BITS = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	tmws_in_if.sink                                 in_ch,
	tmws_out_if.source                              out_ch,
	input  logic                                    cfg_we,
	input  logic [tmws_pkg::CFG_IDX_BITS-1:0]       cfg_idx,
	input  logic [tmws_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	tmws_pkg::cfg_t   cfg_q;
	tmws_pkg::flags_t flags;
	tmws_pkg::op_t    op;
	logic             in_ready;
	logic             out_full;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target   <= tmws_pkg::TGT_RESET;
			cfg_q.ramp     <= tmws_pkg::RAMP_RESET;
			cfg_q.prop     <= tmws_pkg::PROP_RESET;
			cfg_q.integral <= tmws_pkg::INTEGRAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tmws_pkg::REG_TARGET:   cfg_q.target   <= cfg_data[tmws_pkg::TGT_BITS-1:0];
				tmws_pkg::REG_RAMP:     cfg_q.ramp     <= cfg_data[tmws_pkg::RAMP_BITS-1:0];
				tmws_pkg::REG_PROP:     cfg_q.prop     <= cfg_data[tmws_pkg::GAIN_BITS-1:0];
				tmws_pkg::REG_INTEGRAL: cfg_q.integral <= cfg_data[tmws_pkg::GAIN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	tmws_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.out_full (out_full),
		.flags    (flags),
		.op       (op),
		.in_ready (in_ready)
	);

	assign in_ch.ready = in_ready;

	// Datapath.
	tmws_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.op          (op),
		.l_in        (in_ch.left_count),
		.r_in        (in_ch.right_count),
		.out_ready   (out_ch.ready),
		.flags       (flags),
		.out_full    (out_full),
		.out_valid   (out_ch.valid),
		.left_drive  (out_ch.left_drive),
		.right_drive (out_ch.right_drive),
		.done_res    (out_ch.done_res)
	);

endmodule
